[src/tmu_pkg.sv]
// Shared types, codes and constants of the three channel reload timer unit.
`default_nettype none

package tmu_pkg;

  localparam int DEFAULT_CHANNELS = 3;

  localparam int CNT_W  = 32;
  localparam int CR_W   = 16;
  localparam int TOCR_W = 8;
  localparam int PRE_W  = 12;
  localparam int IDX_W  = 4;
  localparam int OP_W   = 2;
  localparam int IRQ_W  = 3;

  // operation codes
  localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_WRITE = 2'd2;

  // register map
  localparam logic [IDX_W-1:0] REG_TOCR = 4'd0;
  localparam logic [IDX_W-1:0] REG_TSTR = 4'd1;
  localparam int REG_CH_BASE = 2;
  localparam int REGS_PER_CH = 3;
  localparam int REG_COR_OFS = 0;
  localparam int REG_CNT_OFS = 1;
  localparam int REG_CR_OFS  = 2;

  // control register bits
  localparam int CR_UNF_BIT = 8;
  localparam int CR_EN_BIT  = 5;
  localparam logic [2:0] MODE_DIV16   = 3'd0;
  localparam logic [2:0] MODE_DIV64   = 3'd1;
  localparam logic [2:0] MODE_DIV256  = 3'd2;
  localparam logic [2:0] MODE_DIV1024 = 3'd3;
  localparam logic [2:0] MODE_DIV4096 = 3'd4;

  typedef struct packed {
    logic tick;    // tick with channel started
    logic wr_cor;
    logic wr_cnt;
    logic wr_cr;
  } chan_ctl_t;

  // prescaler bits that must be zero for a count event
  function automatic logic [PRE_W-1:0] prescale_mask(input logic [2:0] mode);
    logic [PRE_W-1:0] m;
    case (mode)
      MODE_DIV16:   m = 12'h00f;
      MODE_DIV64:   m = 12'h03f;
      MODE_DIV256:  m = 12'h0ff;
      MODE_DIV1024: m = 12'h3ff;
      MODE_DIV4096: m = 12'hfff;
      default:      m = 12'h000;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

[src/tmu_channel.sv]
// One timer channel: reload constant, down counter and control register.
`default_nettype none

module tmu_channel
  import tmu_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire chan_ctl_t        ctl,
  input  wire logic [PRE_W-1:0] prescale_next,
  input  wire logic [CNT_W-1:0] wdata,
  output logic      [CNT_W-1:0] cor,
  output logic      [CNT_W-1:0] cnt,
  output logic      [CR_W-1:0]  cr,
  output logic                  irq_next
);

  logic [CNT_W-1:0] cor_next;
  logic [CNT_W-1:0] cnt_next;
  logic [CR_W-1:0]  cr_next;
  logic             hit;

  // modes above /4096 never count
  assign hit = ctl.tick && (cr[2:0] <= MODE_DIV4096) &&
               ((prescale_next & prescale_mask(cr[2:0])) == '0);

  always_comb begin
    cor_next = cor;
    cnt_next = cnt;
    cr_next  = cr;
    if (hit) begin
      if (cnt == '0) begin
        cnt_next = cor;
        cr_next[CR_UNF_BIT] = 1'b1;
      end else begin
        cnt_next = cnt - 1'b1;
      end
    end
    if (ctl.wr_cor) cor_next = wdata;
    if (ctl.wr_cnt) cnt_next = wdata;
    if (ctl.wr_cr)  cr_next  = wdata[CR_W-1:0];
  end

  assign irq_next = cr_next[CR_UNF_BIT] & cr_next[CR_EN_BIT];

  always_ff @(posedge clk) begin
    if (rst) begin
      cor <= '1;
      cnt <= '1;
      cr  <= '0;
    end else begin
      cor <= cor_next;
      cnt <= cnt_next;
      cr  <= cr_next;
    end
  end

endmodule

`default_nettype wire

[src/three_channel_reload_timer_unit.sv]
// Top level of the reload timer unit: request register, register bank, result register.
`default_nettype none

// Reload timer unit with CHANNELS 32-bit down counters behind a register bank.
// Each request on the slave stream is a peripheral clock tick, a register read
// or a register write, and yields exactly one result on the master stream:
// the read data (zero for ticks and writes) and the interrupt lines as they
// stand after the request took effect. A request is captured in an input
// register and is executed against the register bank once the result
// register is free or being drained; the result then sits in the result
// register and stays there while m_tready is low. One request per cycle is
// sustained while m_tready stays high. All channels and the 12-bit
// prescaler update in parallel on a tick; a started channel in mode 0..4
// counts when the prescaler low bits roll to zero (/16 .. /4096), modes 5..7
// hold. On underflow the counter reloads from its constant and sets control
// bit 8; interrupt line n is that flag ANDed with control bit 5. The offset
// after the last channel (TCPR2) and any higher one reads zero and ignores
// writes.

module three_channel_reload_timer_unit
  import tmu_pkg::*;
#(
  parameter int CHANNELS = DEFAULT_CHANNELS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,   // [3:0] reg_index, [35:4] write_data, [39:36] zero
  input  wire logic [1:0]  s_tuser,   // [1:0] operation
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [39:0] m_tdata    // [31:0] read_data, [34:32] irq_lines, [39:35] zero
);

  // input register
  logic             in_valid;
  logic [OP_W-1:0]  op_q;
  logic [IDX_W-1:0] idx_q;
  logic [CNT_W-1:0] wdata_q;

  // global registers
  logic [PRE_W-1:0]    prescale;
  logic [PRE_W-1:0]    prescale_next;
  logic [CHANNELS-1:0] start_bits;
  logic [TOCR_W-1:0]   tocr;

  logic fire;
  logic s_accept;
  logic is_tick;
  logic is_write;

  chan_ctl_t           ctl   [CHANNELS];
  logic [CNT_W-1:0]    cor   [CHANNELS];
  logic [CNT_W-1:0]    cnt   [CHANNELS];
  logic [CR_W-1:0]     cr    [CHANNELS];
  logic [CHANNELS-1:0] irq_next;
  logic [CHANNELS-1:0] irq_now;
  logic [CHANNELS+IRQ_W-1:0] irq_next_pad;
  logic [CHANNELS+IRQ_W-1:0] irq_now_pad;
  logic [CNT_W-1:0]    rdata;

  // request executes once the result register can take its result
  assign fire     = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || fire;
  assign s_accept = s_tvalid && s_tready;
  assign is_tick  = fire && (op_q == OP_TICK);
  assign is_write = fire && (op_q == OP_WRITE);

  assign prescale_next = prescale + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= s_accept || (in_valid && !fire);
    end
    if (s_accept) begin
      op_q    <= s_tuser;
      idx_q   <= s_tdata[3:0];
      wdata_q <= s_tdata[35:4];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prescale   <= '0;
      start_bits <= '0;
      tocr       <= '0;
    end else begin
      if (is_tick) prescale <= prescale_next;
      if (is_write && idx_q == REG_TSTR) start_bits <= wdata_q[CHANNELS-1:0];
      if (is_write && idx_q == REG_TOCR) tocr <= wdata_q[TOCR_W-1:0];
    end
  end

  // channels
  for (genvar n = 0; n < CHANNELS; n++) begin : g_ch
    localparam int BASE = REG_CH_BASE + REGS_PER_CH * n;

    always_comb begin
      ctl[n].tick   = is_tick && start_bits[n];
      ctl[n].wr_cor = is_write && (32'(idx_q) == 32'(BASE + REG_COR_OFS));
      ctl[n].wr_cnt = is_write && (32'(idx_q) == 32'(BASE + REG_CNT_OFS));
      ctl[n].wr_cr  = is_write && (32'(idx_q) == 32'(BASE + REG_CR_OFS));
    end

    tmu_channel u_ch (
      .clk           (clk),
      .rst           (rst),
      .ctl           (ctl[n]),
      .prescale_next (prescale_next),
      .wdata         (wdata_q),
      .cor           (cor[n]),
      .cnt           (cnt[n]),
      .cr            (cr[n]),
      .irq_next      (irq_next[n])
    );

    assign irq_now[n] = cr[n][CR_UNF_BIT] & cr[n][CR_EN_BIT];
  end

  // register read mux; offsets past the bank fall through to zero
  always_comb begin
    rdata = '0;
    if (op_q == OP_READ) begin
      if (idx_q == REG_TOCR) rdata = CNT_W'(tocr);
      if (idx_q == REG_TSTR) rdata = CNT_W'(start_bits);
      for (int n = 0; n < CHANNELS; n++) begin
        if (32'(idx_q) == 32'(REG_CH_BASE + REGS_PER_CH * n + REG_COR_OFS))
          rdata = cor[n];
        if (32'(idx_q) == 32'(REG_CH_BASE + REGS_PER_CH * n + REG_CNT_OFS))
          rdata = cnt[n];
        if (32'(idx_q) == 32'(REG_CH_BASE + REGS_PER_CH * n + REG_CR_OFS))
          rdata = CNT_W'(cr[n]);
      end
    end
  end

  // only the first three channels reach the interrupt field
  assign irq_next_pad = {{IRQ_W{1'b0}}, irq_next};
  assign irq_now_pad  = {{IRQ_W{1'b0}}, irq_now};

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (fire) begin
      m_tdata <= {5'b0, irq_next_pad[IRQ_W-1:0], rdata};
    end
  end

  // interrupt field of a pending result matches the bank it was taken from
  a_irq_consistent: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[34:32] == irq_now_pad[IRQ_W-1:0]))
    else $error("irq field out of step with channel control");

  // prescaler advances by one on each executed tick
  a_prescale_step: assert property (@(posedge clk) disable iff (rst)
    is_tick |=> (prescale == $past(prescale_next)))
    else $error("prescaler did not advance on tick");

  // no global register moves without an executed request
  a_bank_hold: assert property (@(posedge clk) disable iff (rst)
    !fire |=> ($stable(prescale) && $stable(start_bits) && $stable(tocr)))
    else $error("global registers changed without a request");

  // a held request stays put until it executes
  a_req_hold: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !fire) |=> (in_valid && $stable(op_q) && $stable(idx_q)))
    else $error("pending request lost or changed");

endmodule

`default_nettype wire

[tb/tb_three_channel_reload_timer_unit.sv]
// Self-checking testbench for the three channel reload timer unit.
module tb_three_channel_reload_timer_unit;
  import tmu_pkg::*;

  localparam int CH = DEFAULT_CHANNELS;
  localparam int TIMEOUT = 3_000_000;
  localparam int RANDOM_REQUESTS = 1300;
  localparam int LONG_TICK_RUN = 450;

  // operation code the block treats as a no-op
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

  // register offsets used by the directed rows
  localparam logic [IDX_W-1:0] REG_COR0  = IDX_W'(REG_CH_BASE + REG_COR_OFS);
  localparam logic [IDX_W-1:0] REG_CNT0  = IDX_W'(REG_CH_BASE + REG_CNT_OFS);
  localparam logic [IDX_W-1:0] REG_CR0   = IDX_W'(REG_CH_BASE + REG_CR_OFS);
  localparam logic [IDX_W-1:0] REG_CR1   = IDX_W'(REG_CH_BASE + REGS_PER_CH + REG_CR_OFS);
  localparam logic [IDX_W-1:0] REG_CNT2  = IDX_W'(REG_CH_BASE + 2 * REGS_PER_CH + REG_CNT_OFS);
  localparam logic [IDX_W-1:0] REG_CR2   = IDX_W'(REG_CH_BASE + 2 * REGS_PER_CH + REG_CR_OFS);
  localparam logic [IDX_W-1:0] REG_TCPR2 = IDX_W'(REG_CH_BASE + REGS_PER_CH * CH);
  localparam logic [IDX_W-1:0] REG_VOID  = 4'hf;

  typedef struct {
    logic [CNT_W-1:0] rd;
    logic [IRQ_W-1:0] irq;
  } timer_result_t;

  // one directed request; typed = 1 means the expected result is given here
  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [IDX_W-1:0] idx;
    logic [31:0]      data;
    logic             typed;
    logic [31:0]      rd;
    logic [IRQ_W-1:0] irq;
  } plan_row_t;

  localparam int PLAN_LEN = 25;
  localparam plan_row_t PLAN [PLAN_LEN] = '{
    // reset values
    '{OP_READ,  REG_TOCR,  32'h0000_0000, 1'b1, 32'h0000_0000, 3'd0},
    '{OP_READ,  REG_TSTR,  32'h0000_0000, 1'b1, 32'h0000_0000, 3'd0},
    '{OP_READ,  REG_COR0,  32'hffff_ffff, 1'b1, 32'hffff_ffff, 3'd0},
    '{OP_READ,  REG_CNT0,  32'h0000_0000, 1'b1, 32'hffff_ffff, 3'd0},
    '{OP_READ,  REG_CR0,   32'h0000_0000, 1'b1, 32'h0000_0000, 3'd0},
    '{OP_READ,  REG_TCPR2, 32'h0000_0000, 1'b1, 32'h0000_0000, 3'd0},
    '{OP_READ,  REG_VOID,  32'hffff_ffff, 1'b1, 32'h0000_0000, 3'd0},
    // tick with nothing started, spare opcode does nothing
    '{OP_TICK,  REG_TOCR,  32'hffff_ffff, 1'b1, 32'h0000_0000, 3'd0},
    '{OP_SPARE, REG_TOCR,  32'hffff_ffff, 1'b1, 32'h0000_0000, 3'd0},
    // narrow registers keep their low bits
    '{OP_WRITE, REG_TOCR,  32'hffff_ffff, 1'b1, 32'h0000_0000, 3'd0},
    '{OP_READ,  REG_TOCR,  32'h0000_0000, 1'b1, 32'h0000_00ff, 3'd0},
    '{OP_WRITE, REG_TSTR,  32'hffff_ffff, 1'b1, 32'h0000_0000, 3'd0},
    '{OP_READ,  REG_TSTR,  32'h0000_0000, 1'b1, 32'h0000_0007, 3'd0},
    // control write stores the underflow flag too; mode 7 holds the count
    '{OP_WRITE, REG_CR0,   32'hffff_ffff, 1'b1, 32'h0000_0000, 3'd1},
    '{OP_READ,  REG_CR0,   32'h0000_0000, 1'b1, 32'h0000_ffff, 3'd1},
    '{OP_TICK,  REG_CR0,   32'h0000_0000, 1'b1, 32'h0000_0000, 3'd1},
    '{OP_WRITE, REG_CR0,   32'h0000_0000, 1'b1, 32'h0000_0000, 3'd0},
    // TCPR2 and unused offsets swallow writes
    '{OP_WRITE, REG_TCPR2, 32'hffff_ffff, 1'b1, 32'h0000_0000, 3'd0},
    '{OP_WRITE, REG_VOID,  32'hffff_ffff, 1'b1, 32'h0000_0000, 3'd0},
    '{OP_WRITE, REG_CNT0,  32'h0000_0000, 1'b1, 32'h0000_0000, 3'd0},
    '{OP_WRITE, REG_COR0,  32'h0000_0003, 1'b0, 32'h0000_0000, 3'd0},
    // mode 5 with flag and enable set
    '{OP_WRITE, REG_CR1,   32'h0000_0125, 1'b1, 32'h0000_0000, 3'd2},
    '{OP_WRITE, REG_CR2,   32'h0000_0024, 1'b0, 32'h0000_0000, 3'd0},
    '{OP_READ,  REG_CNT2,  32'h0000_0000, 1'b0, 32'h0000_0000, 3'd0},
    '{OP_TICK,  REG_TOCR,  32'h0000_0000, 1'b0, 32'h0000_0000, 3'd0}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  wire         s_tready;
  logic [39:0] s_tdata = '0;   // [3:0] reg_index, [35:4] write_data, [39:36] zero
  logic [1:0]  s_tuser = '0;   // [1:0] operation
  wire         m_tvalid;
  logic        m_tready = 1'b0;
  wire  [39:0] m_tdata;        // [31:0] read_data, [34:32] irq_lines, [39:35] zero

  // hand-typed expectation that travels with the request
  logic             typed_on = 1'b0;
  logic [31:0]      typed_rd = '0;
  logic [IRQ_W-1:0] typed_irq = '0;

  int idle_odds = 0;       // 0: no idling, else roughly one gap per idle_odds requests
  int requests_sent = 0;
  int stall_left = 0;
  int fail_count = 0;

  // shadow copy of the timer state
  logic [CNT_W-1:0]  shadow_count [CH];
  logic [CNT_W-1:0]  shadow_reload [CH];
  logic [CR_W-1:0]   shadow_ctrl [CH];
  logic [CH-1:0]     shadow_start;
  logic [TOCR_W-1:0] shadow_tocr;
  logic [PRE_W-1:0]  shadow_prescale;

  timer_result_t pending_results [$];

  three_channel_reload_timer_unit #(.CHANNELS(CH)) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Applies one request to the shadow state and returns the result it yields.
  task automatic timer_predict(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                               input logic [31:0] data, output timer_result_t res);
    int ch;
    int sub;
    logic [2:0] mode;
    logic [PRE_W-1:0] low_bits;
    res.rd = '0;
    res.irq = '0;
    ch = (int'(idx) - REG_CH_BASE) / REGS_PER_CH;
    sub = (int'(idx) - REG_CH_BASE) % REGS_PER_CH;
    if (op == OP_TICK) begin
      shadow_prescale = shadow_prescale + 1'b1;
      for (int n = 0; n < CH; n++) begin
        mode = shadow_ctrl[n][2:0];
        // modes above /4096 hold the count
        if (shadow_start[n] && mode <= MODE_DIV4096) begin
          low_bits = PRE_W'((1 << (4 + 2 * mode)) - 1);
          if ((shadow_prescale & low_bits) == '0) begin
            if (shadow_count[n] == '0) begin
              shadow_count[n] = shadow_reload[n];
              shadow_ctrl[n][CR_UNF_BIT] = 1'b1;
            end else begin
              shadow_count[n] = shadow_count[n] - 1'b1;
            end
          end
        end
      end
    end else if (op == OP_READ) begin
      if (idx == REG_TOCR) begin
        res.rd = 32'(shadow_tocr);
      end else if (idx == REG_TSTR) begin
        res.rd = 32'(shadow_start);
      end else if (idx < REG_TCPR2) begin
        case (sub)
          REG_COR_OFS: res.rd = shadow_reload[ch];
          REG_CNT_OFS: res.rd = shadow_count[ch];
          default:     res.rd = 32'(shadow_ctrl[ch]);
        endcase
      end
    end else if (op == OP_WRITE) begin
      if (idx == REG_TOCR) begin
        shadow_tocr = data[TOCR_W-1:0];
      end else if (idx == REG_TSTR) begin
        shadow_start = data[CH-1:0];
      end else if (idx < REG_TCPR2) begin
        case (sub)
          REG_COR_OFS: shadow_reload[ch] = data;
          REG_CNT_OFS: shadow_count[ch] = data;
          default:     shadow_ctrl[ch] = data[CR_W-1:0];
        endcase
      end
    end
    for (int n = 0; n < CH; n++)
      res.irq[n] = shadow_ctrl[n][CR_UNF_BIT] & shadow_ctrl[n][CR_EN_BIT];
  endtask

  // Predicts on every accepted request, checks every accepted result.
  always @(posedge clk) begin : scoreboard
    timer_result_t want;
    timer_result_t got;
    if (rst) begin
      for (int n = 0; n < CH; n++) begin
        shadow_count[n] = '1;
        shadow_reload[n] = '1;
        shadow_ctrl[n] = '0;
      end
      shadow_start = '0;
      shadow_tocr = '0;
      shadow_prescale = '0;
      pending_results.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got.rd = m_tdata[31:0];
        got.irq = m_tdata[34:32];
        if (pending_results.size() == 0) begin
          $error("result with no request pending: read_data %h irq_lines %b", got.rd, got.irq);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (got.rd !== want.rd) begin
            $error("read_data: expected %h, got %h", want.rd, got.rd);
            fail_count++;
          end
          if (got.irq !== want.irq) begin
            $error("irq_lines: expected %b, got %b", want.irq, got.irq);
            fail_count++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        timer_predict(s_tuser, s_tdata[3:0], s_tdata[35:4], want);
        if (typed_on) begin
          want.rd = typed_rd;
          want.irq = typed_irq;
        end
        pending_results.push_back(want);
      end
    end
  end

  // Result side back-pressure: random stall bursts while idle_odds is nonzero.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 1'b0;
    end else if (idle_odds != 0 && $urandom_range(0, idle_odds * 3) == 0) begin
      stall_left <= $urandom_range(0, 17);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Drives one request and waits for it to be taken; may idle afterwards.
  task automatic push_request(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                              input logic [31:0] data, input logic typed,
                              input logic [31:0] rd, input logic [IRQ_W-1:0] irq);
    s_tuser <= op;
    s_tdata <= {4'b0, data, idx};
    typed_on <= typed;
    typed_rd <= rd;
    typed_irq <= irq;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    requests_sent++;
    if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  task automatic request(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                         input logic [31:0] data);
    push_request(op, idx, data, 1'b0, '0, '0);
  endtask

  function automatic logic [IDX_W-1:0] chan_reg(input int ch, input int ofs);
    return IDX_W'(REG_CH_BASE + REGS_PER_CH * ch + ofs);
  endfunction

  // small counts dominate so that underflows come often
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 5))
      0, 1, 2: return 32'($urandom_range(0, 40));
      3:       return $urandom;
      4:       return 32'hffff_ffff;
      default: return 32'h1 << $urandom_range(0, 31);
    endcase
  endfunction

  // control word, mostly a fast prescale mode
  function automatic logic [31:0] pick_control();
    logic [31:0] w;
    w = $urandom;
    if ($urandom_range(0, 3) != 0)
      w[2:0] = 3'($urandom_range(MODE_DIV16, MODE_DIV256));
    return w;
  endfunction

  task automatic random_session();
    int ch;
    logic [31:0] w;
    ch = $urandom_range(0, CH - 1);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: begin
        // loose single request, noise included
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10:
            request(OP_TICK, 4'($urandom), $urandom);
          11, 12, 13, 14:
            request(OP_READ, 4'($urandom), $urandom);
          15, 16, 17, 18:
            request(OP_WRITE, 4'($urandom), pick_word());
          default:
            request(OP_SPARE, 4'($urandom), $urandom);
        endcase
      end
      5, 6: begin
        // run of ticks with an occasional counter peek
        repeat ($urandom_range(16, 160)) begin
          if ($urandom_range(0, 9) == 0)
            request(OP_READ, chan_reg($urandom_range(0, CH - 1), REG_CNT_OFS), $urandom);
          else
            request(OP_TICK, 4'($urandom), $urandom);
        end
      end
      7: begin
        // program a channel and (re)start
        request(OP_WRITE, chan_reg(ch, REG_COR_OFS), pick_word());
        request(OP_WRITE, chan_reg(ch, REG_CNT_OFS), pick_word());
        request(OP_WRITE, chan_reg(ch, REG_CR_OFS), pick_control());
        w = $urandom;
        if ($urandom_range(0, 1) != 0)
          w[CH-1:0] = '1;
        request(OP_WRITE, REG_TSTR, w);
      end
      8: begin
        // service an interrupt: read control, clear the flag
        request(OP_READ, chan_reg(ch, REG_CR_OFS), $urandom);
        w = pick_control();
        w[CR_UNF_BIT] = 1'b0;
        request(OP_WRITE, chan_reg(ch, REG_CR_OFS), w);
      end
      default: begin
        request(OP_READ, REG_TOCR, $urandom);
        request(OP_READ, REG_TSTR, $urandom);
        request(OP_READ, chan_reg(ch, REG_COR_OFS), $urandom);
        request(OP_READ, chan_reg(ch, REG_CNT_OFS), $urandom);
        request(OP_READ, chan_reg(ch, REG_CR_OFS), $urandom);
      end
    endcase
  endtask

  initial begin : stimulus
    logic [31:0] w;
    int goal;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < PLAN_LEN; i++)
      push_request(PLAN[i].op, PLAN[i].idx, PLAN[i].data, PLAN[i].typed,
                   PLAN[i].rd, PLAN[i].irq);

    // random part in quarters, idling in every other one
    for (int q = 0; q < 4; q++) begin
      idle_odds = (q % 2 == 0) ? $urandom_range(3, 8) : 0;
      goal = requests_sent + RANDOM_REQUESTS / 4;
      while (requests_sent < goal)
        random_session();
    end

    // closing stretch, no idling: slow modes back to back
    idle_odds = 0;
    w = '0;
    w[CR_EN_BIT] = 1'b1;
    w[2:0] = MODE_DIV4096;
    request(OP_WRITE, REG_CNT2, 32'h0);
    request(OP_WRITE, chan_reg(2, REG_COR_OFS), 32'h2);
    request(OP_WRITE, REG_CR2, w);
    w[2:0] = MODE_DIV1024;
    request(OP_WRITE, REG_CNT0, 32'h1);
    request(OP_WRITE, REG_CR0, w);
    request(OP_WRITE, REG_TSTR, 32'hffff_ffff);
    for (int i = 0; i < LONG_TICK_RUN; i++) begin
      if (i % 50 == 49)
        request(OP_READ, chan_reg(i % CH, REG_CNT_OFS), $urandom);
      else
        request(OP_TICK, 4'($urandom), $urandom);
    end
    for (int r = 0; r < 16; r++)
      request(OP_READ, IDX_W'(r), $urandom);
    s_tvalid <= 1'b0;

    while (pending_results.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0)
      $display("PASS three_channel_reload_timer_unit");
    else
      $display("FAIL three_channel_reload_timer_unit");
    $finish;
  end

  initial begin
    #TIMEOUT;
    $display("FAIL three_channel_reload_timer_unit");
    $finish;
  end

endmodule
